>>> src/life_like_cellular_automaton_top_assert.svh
// ----------------------------------------------------------------------------
// life-like cellular automaton assertion macros
// concurrent checks on the top level, clocked by clk, off during reset
// ----------------------------------------------------------------------------
`ifndef LIFE_LIKE_CELLULAR_AUTOMATON_TOP_ASSERT_SVH
`define LIFE_LIKE_CELLULAR_AUTOMATON_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LLCA_AST_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("llca check failed");

// antecedent implies consequent in the next cycle
`define LLCA_AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("llca check failed");

`endif

>>> src/llca_pkg.sv
// ----------------------------------------------------------------------------
// llca_pkg
// shared types and constants of the life-like cellular automaton
// ----------------------------------------------------------------------------
package llca_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam int CNT_W      = 4;

	// item kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_STEP  = 2'd2;
	localparam logic [1:0] KIND_RSVD  = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIDE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BORN_MIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BORN_MAX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SURV_MIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SURV_MAX = 3'd4;

	// register reset values
	localparam logic [6:0]       RST_SIDE     = 7'd64;
	localparam logic [CNT_W-1:0] RST_BORN_MIN = 4'd3;
	localparam logic [CNT_W-1:0] RST_BORN_MAX = 4'd3;
	localparam logic [CNT_W-1:0] RST_SURV_MIN = 4'd2;
	localparam logic [CNT_W-1:0] RST_SURV_MAX = 4'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] row;
		logic [5:0] col;
		logic       value;
	} llca_cmd_t;

	typedef struct packed {
		logic [1:0] done_kind;
		logic       cell_value;
	} llca_res_t;

	typedef struct packed {
		logic [CNT_W-1:0] born_min;
		logic [CNT_W-1:0] born_max;
		logic [CNT_W-1:0] survive_min;
		logic [CNT_W-1:0] survive_max;
	} llca_rule_t;

endpackage

>>> src/llca_ram.sv
// ----------------------------------------------------------------------------
// llca_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module llca_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/llca_cell.sv
// ----------------------------------------------------------------------------
// llca_cell
// one column of the sweep window: three stacked cells and the life rule
// ----------------------------------------------------------------------------
module llca_cell
	import llca_pkg::*;
(
	input  logic       clk,
	input  logic       clear,
	input  logic       shift,
	input  logic       in_bit,
	input  logic       active,
	input  logic [1:0] left_sum,
	input  logic [1:0] right_sum,
	input  llca_rule_t rule,
	output logic [1:0] col_sum,
	output logic       next_bit
);

	logic             up_q, mid_q, dn_q;
	logic [CNT_W-1:0] count;
	logic             survive, born;

	// window moves down one row per shift
	always_ff @(posedge clk) begin
		if (clear) begin
			up_q  <= 1'b0;
			mid_q <= 1'b0;
			dn_q  <= 1'b0;
		end else if (shift) begin
			up_q  <= mid_q;
			mid_q <= dn_q;
			dn_q  <= in_bit;
		end
	end

	// inactive columns look dead to their neighbors
	assign col_sum = active ? (2'(up_q) + 2'(mid_q) + 2'(dn_q)) : 2'd0;

	assign count = CNT_W'(left_sum) + CNT_W'(col_sum) + CNT_W'(right_sum)
		- CNT_W'(mid_q & active);

	assign survive = (count >= rule.survive_min) && (count <= rule.survive_max);
	assign born    = (count >= rule.born_min) && (count <= rule.born_max);

	// inactive columns keep their state
	assign next_bit = active ? (mid_q ? survive : born) : mid_q;

endmodule

>>> src/life_like_cellular_automaton_top.sv
// ----------------------------------------------------------------------------
// life_like_cellular_automaton_top
// square grid of one-bit cells with write, read and one-generation advance
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result shows
// on result for the single cycle that done is high, and the receiver cannot
// stall it. Write and read step through accept, row read and row write-back,
// since a cell sits inside a row-wide ram word and is updated by
// read-modify-write. An advance sweeps the active square one row per
// cycle through a three-row window held in a chain of column cells, one row
// read and one row written back per cycle. An unused kind, or an advance
// with a side of zero, completes from the accept with no row access. The
// grid reads as all dead after reset with no clearing pass: each row carries
// a valid flag that reset clears. The user must write the side and rule
// registers on the cfg port only while the block is idle; the block itself
// does not enforce this. They take effect with the next item.
// ----------------------------------------------------------------------------
`include "life_like_cellular_automaton_top_assert.svh"

module life_like_cellular_automaton_top
	import llca_pkg::*;
#(
	parameter int MAX_SIDE = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  llca_cmd_t             cmd,
	output logic                  done,
	output llca_res_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// row address and side widths
	localparam int AW = $clog2(MAX_SIDE);
	localparam int SW = $clog2(MAX_SIDE + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RD    = 3'd1;
	localparam logic [2:0] S_WB    = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;

	// configuration
	logic [6:0]   side_q;
	llca_rule_t   rule_q;
	logic [SW-1:0] act_side;

	// control
	logic [2:0]    state_q;
	llca_cmd_t     cmd_q;
	logic [SW-1:0] cnt_q;
	logic          acc;
	logic          in_grid;
	logic          fin;
	llca_res_t     res_nxt;
	logic          done_q;
	llca_res_t     res_q;

	// sweep pipeline: s1 shifts a row into the window, s2 writes a new row
	logic          shift_s1;
	logic [SW-1:0] idx_s1;
	logic          rvld_s1;
	logic          wr_s2;
	logic          last_s2;
	logic [AW-1:0] widx_s2;

	// row store
	logic [MAX_SIDE-1:0] row_vld_q;
	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [MAX_SIDE-1:0] ram_wdata, ram_rdata;
	logic [MAX_SIDE-1:0] row_in;
	logic [MAX_SIDE-1:0] wb_row;
	logic [AW-1:0]       col_idx;

	// cell chain
	logic [MAX_SIDE-1:0] col_act;
	logic [MAX_SIDE-1:0] next_row;
	logic [1:0]          col_sum [MAX_SIDE];
	logic                win_clear;

	// side saturates at the grid size
	assign act_side = (int'(side_q) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(side_q);

	assign acc     = start && (state_q == S_IDLE);
	assign busy    = (state_q != S_IDLE);
	assign in_grid = (int'(cmd_q.row) < MAX_SIDE) && (int'(cmd_q.col) < MAX_SIDE);
	assign col_idx = AW'(cmd_q.col);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q             <= RST_SIDE;
			rule_q.born_min    <= RST_BORN_MIN;
			rule_q.born_max    <= RST_BORN_MAX;
			rule_q.survive_min <= RST_SURV_MIN;
			rule_q.survive_max <= RST_SURV_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIDE:     side_q             <= cfg_data;
				REG_BORN_MIN: rule_q.born_min    <= cfg_data[CNT_W-1:0];
				REG_BORN_MAX: rule_q.born_max    <= cfg_data[CNT_W-1:0];
				REG_SURV_MIN: rule_q.survive_min <= cfg_data[CNT_W-1:0];
				REG_SURV_MAX: rule_q.survive_max <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// row store: ram plus one valid flag per row, invalid rows read dead
	// ------------------------------------------------------------------
	llca_ram #(
		.WIDTH (MAX_SIDE),
		.DEPTH (MAX_SIDE)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// read side: item row in S_RD, sweep row counter in S_SWEEP
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = AW'(cmd_q.row);
		if (state_q == S_RD) begin
			ram_re = in_grid;
		end else if (state_q == S_SWEEP) begin
			ram_re    = (cnt_q < act_side);
			ram_raddr = AW'(cnt_q);
		end
	end

	// a row past the active side, or never written, enters as all dead
	assign row_in = ram_rdata & {MAX_SIDE{rvld_s1}};

	// single-cell update merged into the row just read
	always_comb begin
		wb_row          = row_in;
		wb_row[col_idx] = cmd_q.value;
	end

	// write side: item write-back or a new generation row
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(cmd_q.row);
		ram_wdata = wb_row;
		if (wr_s2) begin
			ram_we    = 1'b1;
			ram_waddr = widx_s2;
			ram_wdata = next_row;
		end else if ((state_q == S_WB) && (cmd_q.kind == KIND_WRITE) && in_grid) begin
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rvld_s1   <= 1'b0;
		end else begin
			if (ram_we) begin
				row_vld_q[ram_waddr] <= 1'b1;
			end
			rvld_s1 <= ram_re && row_vld_q[ram_raddr];
		end
	end

	// ------------------------------------------------------------------
	// chain of column cells; each hands its column sum to both neighbors
	// ------------------------------------------------------------------
	assign win_clear = acc && (cmd.kind == KIND_STEP);

	for (genvar c = 0; c < MAX_SIDE; c++) begin : g_cell
		logic [1:0] lsum, rsum;

		if (c == 0) begin : g_left_edge
			assign lsum = 2'd0;
		end else begin : g_left
			assign lsum = col_sum[c-1];
		end

		if (c == MAX_SIDE - 1) begin : g_right_edge
			assign rsum = 2'd0;
		end else begin : g_right
			assign rsum = col_sum[c+1];
		end

		assign col_act[c] = (SW'(c) < act_side);

		llca_cell u_cell (
			.clk       (clk),
			.clear     (win_clear),
			.shift     (shift_s1),
			.in_bit    (row_in[c]),
			.active    (col_act[c]),
			.left_sum  (lsum),
			.right_sum (rsum),
			.rule      (rule_q),
			.col_sum   (col_sum[c]),
			.next_bit  (next_row[c])
		);
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	// item completes on immediate kinds, after write-back, or at the last
	// generation row
	always_comb begin
		fin = 1'b0;
		if (acc) begin
			fin = (cmd.kind == KIND_RSVD) || ((cmd.kind == KIND_STEP) && (act_side == '0));
		end else if (state_q == S_WB) begin
			fin = 1'b1;
		end else if (state_q == S_DRAIN) begin
			fin = last_s2;
		end
	end

	always_comb begin
		res_nxt.done_kind  = (state_q == S_IDLE) ? cmd.kind : cmd_q.kind;
		res_nxt.cell_value = (state_q == S_WB) && (cmd_q.kind == KIND_READ) && in_grid
			&& row_in[col_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			shift_s1 <= 1'b0;
			wr_s2    <= 1'b0;
			last_s2  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q   <= fin;
			shift_s1 <= (state_q == S_SWEEP);
			wr_s2    <= shift_s1 && (idx_s1 != '0);
			last_s2  <= shift_s1 && (idx_s1 == act_side);
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						cnt_q <= '0;
						unique case (cmd.kind) inside
							KIND_WRITE, KIND_READ: state_q <= S_RD;
							KIND_STEP: begin
								if (act_side != '0) begin
									state_q <= S_SWEEP;
								end
							end
							default: ;
						endcase
					end
				end
				S_RD: begin
					state_q <= S_WB;
				end
				S_WB: begin
					state_q <= S_IDLE;
				end
				S_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == act_side) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (last_s2) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q <= cmd;
		end
		idx_s1  <= cnt_q;
		widx_s2 <= AW'(idx_s1 - 1'b1);
		if (fin) begin
			res_q <= res_nxt;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`LLCA_AST_NEXT(a_acc_progress, start && !busy, busy || done)
	`LLCA_AST_IMPL(a_wr_after_shift, wr_s2, $past(shift_s1))
	`LLCA_AST_IMPL(a_we_busy, ram_we, busy)

endmodule
